FILE: design/sfnf_pkg.sv
// Shared types, character codes and helpers for the short file name formatter.
// Used by the front, queue, back and top-level modules. No dependencies.
`default_nettype none

package sfnf_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Field geometry and limits
    localparam int NAME_BYTES  = 8;
    localparam int EXT_BYTES   = 3;
    localparam int NAME_BITS   = NAME_BYTES * 8;
    localparam int EXT_BITS    = EXT_BYTES * 8;
    localparam logic [3:0] STORE_DEPTH = 4'd12;
    localparam logic [3:0] LEN_MAX     = 4'd15;
    localparam logic [1:0] DOT_MAX     = 2'd3;

    localparam logic [NAME_BITS-1:0] BASE_BLANK = {NAME_BYTES{CH_SPACE}};
    localparam logic [EXT_BITS-1:0]  EXT_BLANK  = {EXT_BYTES{CH_SPACE}};

    // One finished name, as handed from front to back
    typedef struct packed {
        logic [NAME_BITS-1:0] base;
        logic [EXT_BITS-1:0]  ext;
        logic [3:0]           len;
        logic [3:0]           dot_pos;
        logic [1:0]           dot_cnt;
        logic                 bad;
    } t_name_rec;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // A-Z, 0-9, underscore, hyphen
    function automatic logic is_name_char(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h30) && (c <= 8'h39)) ||
               (c == CH_UNDER) || (c == CH_HYPHEN);
    endfunction

endpackage

`default_nettype wire

FILE: design/sfnf_queue.sv
// Two-entry queue of finished name records between front and back.
// Depends on sfnf_pkg.
`default_nettype none

module sfnf_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  sfnf_pkg::t_name_rec     i_rec,
    input  wire logic               i_pop,
    output sfnf_pkg::t_name_rec     o_rec,
    output sfnf_pkg::t_q_stat       o_stat
);
    import sfnf_pkg::*;

    t_name_rec  r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign w_push = i_push && (r_cnt != 2'd2);
    assign w_pop  = i_pop && (r_cnt != 2'd0);

    assign o_rec        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_rec;
    end

endmodule

`default_nettype wire

FILE: design/sfnf_front.sv
// Front part: takes one character per cycle unless the queue is full; tracks
// length, dots and bad characters, fills base and ext slots. Uses sfnf_pkg.
`default_nettype none

module sfnf_front #(
    parameter int BASE_CHARS = 8,
    parameter int EXT_CHARS  = 3
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [7:0]         i_character,
    input  sfnf_pkg::t_q_stat       i_q_stat,
    output logic                    o_stall,
    output logic                    o_push,
    output sfnf_pkg::t_name_rec     o_rec
);
    import sfnf_pkg::*;

    logic [NAME_BITS-1:0] r_base, n_base;
    logic [EXT_BITS-1:0]  r_ext, n_ext;
    logic [3:0]           r_len, n_len;
    logic [3:0]           r_dot_pos, n_dot_pos;
    logic [1:0]           r_dot_cnt, n_dot_cnt;
    logic                 r_bad, n_bad;
    logic                 w_accept;
    logic                 w_is_dot;
    logic [3:0]           w_ext_idx;

    assign o_stall   = i_q_stat.full;
    assign w_accept  = i_valid && !i_q_stat.full;
    assign w_is_dot  = (i_character == CH_DOT);
    // slot after the dot; only meaningful with exactly one dot seen
    assign w_ext_idx = r_len - r_dot_pos - 4'd1;

    assign o_rec.base    = r_base;
    assign o_rec.ext     = r_ext;
    assign o_rec.len     = r_len;
    assign o_rec.dot_pos = r_dot_pos;
    assign o_rec.dot_cnt = r_dot_cnt;
    assign o_rec.bad     = r_bad;

    // Next-state for the name being collected
    always_comb begin
        n_base    = r_base;
        n_ext     = r_ext;
        n_len     = r_len;
        n_dot_pos = r_dot_pos;
        n_dot_cnt = r_dot_cnt;
        n_bad     = r_bad;
        o_push    = 1'b0;
        if (w_accept) begin
            if (i_character == CH_NUL) begin
                // end of name: hand the record over and start fresh
                o_push    = 1'b1;
                n_base    = BASE_BLANK;
                n_ext     = EXT_BLANK;
                n_len     = 4'd0;
                n_dot_pos = 4'd0;
                n_dot_cnt = 2'd0;
                n_bad     = 1'b0;
            end else begin
                if (w_is_dot) begin
                    n_dot_pos = r_len;
                    if (r_dot_cnt != DOT_MAX) n_dot_cnt = r_dot_cnt + 2'd1;
                end else begin
                    if (!is_name_char(i_character)) n_bad = 1'b1;
                    // base slots before any dot
                    for (int k = 0; k < BASE_CHARS; k++) begin
                        if ((r_dot_cnt == 2'd0) && (r_len == 4'(k)))
                            n_base[NAME_BITS-1-8*k -: 8] = i_character;
                    end
                    // extension slots after the single dot
                    for (int k = 0; k < EXT_CHARS; k++) begin
                        if ((r_dot_cnt == 2'd1) && (w_ext_idx == 4'(k)))
                            n_ext[EXT_BITS-1-8*k -: 8] = i_character;
                    end
                end
                if (r_len != LEN_MAX) n_len = r_len + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= BASE_BLANK;
            r_ext     <= EXT_BLANK;
            r_len     <= 4'd0;
            r_dot_pos <= 4'd0;
            r_dot_cnt <= 2'd0;
            r_bad     <= 1'b0;
        end else begin
            r_base    <= n_base;
            r_ext     <= n_ext;
            r_len     <= n_len;
            r_dot_pos <= n_dot_pos;
            r_dot_cnt <= n_dot_cnt;
            r_bad     <= n_bad;
        end
    end

endmodule

`default_nettype wire

FILE: design/sfnf_back.sv
// Back part: checks a finished name against the 8.3 rules and holds the
// result in the output register until taken. Uses sfnf_pkg.
`default_nettype none

module sfnf_back #(
    parameter int BASE_CHARS = 8,
    parameter int EXT_CHARS  = 3
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  sfnf_pkg::t_name_rec                 i_rec,
    input  sfnf_pkg::t_q_stat                   i_q_stat,
    output logic                                o_pop,
    input  wire logic                           i_stall,
    output logic                                o_valid,
    output logic [sfnf_pkg::NAME_BITS-1:0]      o_base_name,
    output logic [sfnf_pkg::EXT_BITS-1:0]       o_extension,
    output logic                                o_accepted
);
    import sfnf_pkg::*;

    logic                 r_valid;
    logic [NAME_BITS-1:0] r_base;
    logic [EXT_BITS-1:0]  r_ext;
    logic                 r_ok;
    logic                 w_ok;
    logic [3:0]           w_blen, w_elen;

    // Rule check on the record at the queue head
    always_comb begin
        w_ok   = !i_rec.bad && (i_rec.len != 4'd0) && (i_rec.len <= STORE_DEPTH) &&
                 (i_rec.dot_cnt <= 2'd1);
        w_blen = i_rec.len;
        w_elen = 4'd0;
        if (w_ok && (i_rec.dot_cnt == 2'd1)) begin
            if ((i_rec.dot_pos == 4'd0) || (i_rec.dot_pos == i_rec.len - 4'd1)) begin
                w_ok = 1'b0;
            end else begin
                w_blen = i_rec.dot_pos;
                w_elen = i_rec.len - i_rec.dot_pos - 4'd1;
            end
        end
        if ((w_blen > 4'(BASE_CHARS)) || (w_elen > 4'(EXT_CHARS))) w_ok = 1'b0;
    end

    // Load the output register when it is free or being taken
    assign o_pop = !i_q_stat.empty && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ok   <= w_ok;
            r_base <= w_ok ? i_rec.base : BASE_BLANK;
            r_ext  <= w_ok ? i_rec.ext  : EXT_BLANK;
        end
    end

    assign o_valid     = r_valid;
    assign o_base_name = r_base;
    assign o_extension = r_ext;
    assign o_accepted  = r_ok;

endmodule

`default_nettype wire

FILE: design/short_file_name_formatter.sv
// Top level of the 8.3 short file name formatter: front, record queue, back.
// Depends on sfnf_pkg, sfnf_front, sfnf_queue and sfnf_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in      | input     | i_valid / o_stall    | i_character[7:0]
//   out     | output    | o_valid / i_stall    | o_base_name[63:0], o_extension[23:0],
//           |           |                      | o_accepted
//
// One character is taken every cycle unless o_stall is high; the front updates
// its counters and one name slot per character. A zero byte pushes the name into a
// two-entry queue; the back moves its result into the output register once free.
// o_stall rises only when the queue holds two names while output is stalled.
// Reset (synchronous, active low) empties the queue and output and starts a
// new name.
`default_nettype none

module short_file_name_formatter #(
    parameter int BASE_CHARS = 8,
    parameter int EXT_CHARS  = 3
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [7:0]                     i_character,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [sfnf_pkg::NAME_BITS-1:0]      o_base_name,
    output logic [sfnf_pkg::EXT_BITS-1:0]       o_extension,
    output logic                                o_accepted
);
    import sfnf_pkg::*;

    logic      w_push, w_pop;
    t_name_rec w_front_rec, w_head_rec;
    t_q_stat   w_q_stat;

    sfnf_front #(
        .BASE_CHARS(BASE_CHARS),
        .EXT_CHARS (EXT_CHARS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_character(i_character),
        .i_q_stat   (w_q_stat),
        .o_stall    (o_stall),
        .o_push     (w_push),
        .o_rec      (w_front_rec)
    );

    sfnf_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_rec  (w_front_rec),
        .i_pop  (w_pop),
        .o_rec  (w_head_rec),
        .o_stat (w_q_stat)
    );

    sfnf_back #(
        .BASE_CHARS(BASE_CHARS),
        .EXT_CHARS (EXT_CHARS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rec      (w_head_rec),
        .i_q_stat   (w_q_stat),
        .o_pop      (w_pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_base_name(o_base_name),
        .o_extension(o_extension),
        .o_accepted (o_accepted)
    );

    // A rejected name shows all spaces
    a_reject_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |-> ((o_base_name == BASE_BLANK) &&
                                      (o_extension == EXT_BLANK)))
        else $error("rejected name carries characters");

    // An accepted name starts with a real character
    a_accept_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_accepted) |-> (o_base_name[NAME_BITS-1 -: 8] != CH_SPACE))
        else $error("accepted name has blank first character");

    // Extension padding is contiguous
    a_ext_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_extension[EXT_BITS-1 -: 8] == CH_SPACE)) |->
            (o_extension[EXT_BITS-9:0] == EXT_BLANK[EXT_BITS-9:0]))
        else $error("extension padding has a gap");

    // No result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking bench for the 8.3 short file name formatter: a clocked driver, a monitor
// and a scoreboard that predicts each padded name from the character stream.
// Depends on sfnf_pkg and short_file_name_formatter.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfnf_pkg::*;

    localparam int BASE_LIMIT  = 8;
    localparam int EXT_LIMIT   = 3;
    localparam int RANDOM_CHARS = 1550;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int PRINT_LIMIT = 40;

    typedef struct {
        logic [NAME_BITS-1:0] base;
        logic [EXT_BITS-1:0]  ext;
        logic                 ok;
    } name_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic [7:0]           i_character = 8'h00;
    logic                 i_stall = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [NAME_BITS-1:0] o_base_name;
    logic [EXT_BITS-1:0]  o_extension;
    logic                 o_accepted;

    short_file_name_formatter #(
        .BASE_CHARS(BASE_LIMIT),
        .EXT_CHARS (EXT_LIMIT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_character(i_character),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_base_name(o_base_name),
        .o_extension(o_extension),
        .o_accepted (o_accepted)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [7:0]   pending_chars[$];
    logic [7:0]   draft[$];
    name_result_t name_results[$];

    int         stim_total = 0;
    int         sent_count = 0;
    int         names_checked = 0;
    int         names_valid = 0;
    int         error_count = 0;
    int         cycles = 0;
    logic [1:0] mix_phase = 2'd0;

    // Predictor copy of the name being collected
    logic [7:0] seen_chars[12];
    logic [3:0] seen_len = 4'd0;
    logic [3:0] dot_at = 4'd0;
    logic [1:0] dot_seen = 2'd0;
    logic       bad_char = 1'b0;

    function automatic bit short_name_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
               c == CH_UNDER || c == CH_HYPHEN;
    endfunction

    // Fold one accepted character into the name; a NUL closes it and queues the result
    task automatic take_character(input logic [7:0] c);
        name_result_t r;
        int len, blen, elen, idx;
        bit ok;
        if (c != CH_NUL) begin
            if (c == CH_DOT) begin
                dot_at = seen_len;
                if (dot_seen != DOT_MAX) dot_seen = dot_seen + 2'd1;
            end else if (!short_name_char(c)) begin
                bad_char = 1'b1;
            end
            if (seen_len < STORE_DEPTH) seen_chars[seen_len] = c;
            if (seen_len != LEN_MAX) seen_len = seen_len + 4'd1;
        end else begin
            len  = int'(seen_len);
            ok   = !bad_char && len != 0 && len <= int'(STORE_DEPTH) && dot_seen <= 2'd1;
            blen = len;
            elen = 0;
            if (ok && dot_seen == 2'd1) begin
                if (dot_at == 4'd0 || int'(dot_at) == len - 1) begin
                    ok = 1'b0;
                end else begin
                    blen = int'(dot_at);
                    elen = len - int'(dot_at) - 1;
                end
            end
            if (ok && (blen > BASE_LIMIT || elen > EXT_LIMIT)) ok = 1'b0;
            for (int k = 0; k < NAME_BYTES; k++) begin
                r.base[(NAME_BYTES-1-k)*8 +: 8] = (ok && k < blen) ? seen_chars[k] : CH_SPACE;
            end
            for (int k = 0; k < EXT_BYTES; k++) begin
                idx = blen + 1 + k;
                r.ext[(EXT_BYTES-1-k)*8 +: 8] = (ok && k < elen) ? seen_chars[idx] : CH_SPACE;
            end
            r.ok = ok;
            name_results.push_back(r);
            seen_len = 4'd0;
            dot_at   = 4'd0;
            dot_seen = 2'd0;
            bad_char = 1'b0;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch on name %0d, %s: got %h, expected %h",
                     names_checked, what, got, want);
    endtask

    function automatic int send_idle_pct(input logic [1:0] ph);
        return (ph == 2'd0) ? 24 : (ph == 2'd1) ? 56 : 0;
    endfunction

    function automatic int recv_stall_pct(input logic [1:0] ph);
        return (ph == 2'd0) ? 56 : (ph == 2'd1) ? 24 : 0;
    endfunction

    // Driver: hold a stalled item, otherwise offer the next one or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_character <= 8'h00;
        end else begin
            if (i_valid && !o_stall) begin
                take_character(i_character);
                sent_count <= sent_count + 1;
                if (stim_total > 0)
                    mix_phase <= ((sent_count + 1) * 3 / stim_total >= 2) ? 2'd2 :
                                 2'((sent_count + 1) * 3 / stim_total);
            end
            if (!i_valid || !o_stall) begin
                if (pending_chars.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct(mix_phase)) begin
                    i_valid     <= 1'b1;
                    i_character <= pending_chars.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken result against the oldest prediction
    always @(posedge i_clk) begin
        name_result_t want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (name_results.size() == 0) begin
                    flag_mismatch("unexpected result", o_base_name, 64'd0);
                end else begin
                    want = name_results.pop_front();
                    if (o_base_name !== want.base)
                        flag_mismatch("base name", o_base_name, want.base);
                    if (o_extension !== want.ext)
                        flag_mismatch("extension", 64'(o_extension), 64'(want.ext));
                    if (o_accepted !== want.ok)
                        flag_mismatch("accepted", 64'(o_accepted), 64'(want.ok));
                    if (want.ok) names_valid++;
                end
                names_checked++;
            end
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct(mix_phase));
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, name_results.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [7:0] legal_pick();
        int r;
        r = $urandom_range(0, 37);
        if (r < 26) return 8'("A" + r);
        if (r < 36) return 8'("0" + r - 26);
        return (r == 36) ? CH_UNDER : CH_HYPHEN;
    endfunction

    function automatic logic [7:0] rogue_pick();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (short_name_char(c) || c == CH_DOT);
        return c;
    endfunction

    task automatic append_legal(input int n);
        for (int k = 0; k < n; k++) draft.push_back(legal_pick());
    endtask

    // Move the draft into the stream, closed by a NUL
    task automatic commit_draft();
        foreach (draft[k]) pending_chars.push_back(draft[k]);
        pending_chars.push_back(CH_NUL);
        draft.delete();
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) draft.push_back(s[k]);
        commit_draft();
    endtask

    // One random name, mostly well formed, the rest broken in one way or another
    task automatic make_random_name();
        int kind, n, e;
        kind = $urandom_range(0, 99);
        draft.delete();
        if (kind < 60) begin
            append_legal(($urandom_range(0, 3) == 0) ? BASE_LIMIT : $urandom_range(1, 8));
            if ($urandom_range(0, 9) < 6) begin
                draft.push_back(CH_DOT);
                append_legal($urandom_range(1, 3));
            end
        end else if (kind < 65) begin
            // base too long, with and without an extension
            if ($urandom_range(0, 1) == 0) begin
                append_legal($urandom_range(9, 12));
            end else begin
                append_legal($urandom_range(9, 10));
                draft.push_back(CH_DOT);
                append_legal(1);
            end
        end else if (kind < 70) begin
            // extension too long
            n = $urandom_range(1, 7);
            e = $urandom_range(4, 11 - n);
            append_legal(n);
            draft.push_back(CH_DOT);
            append_legal(e);
        end else if (kind < 75) begin
            // dot leading or trailing
            if ($urandom_range(0, 1) == 0) begin
                draft.push_back(CH_DOT);
                append_legal($urandom_range(0, 3));
            end else begin
                append_legal($urandom_range(1, 8));
                draft.push_back(CH_DOT);
            end
        end else if (kind < 80) begin
            // several dots
            append_legal($urandom_range(2, 10));
            n = $urandom_range(2, 3);
            for (int k = 0; k < n; k++) draft[$urandom_range(0, draft.size() - 1)] = CH_DOT;
        end else if (kind < 85) begin
            // one illegal byte in an otherwise good name
            append_legal($urandom_range(1, 8));
            if ($urandom_range(0, 1) == 0) begin
                draft.push_back(CH_DOT);
                append_legal($urandom_range(1, 3));
            end
            draft[$urandom_range(0, draft.size() - 1)] = rogue_pick();
        end else if (kind < 90) begin
            // overlong
            append_legal($urandom_range(13, 20));
            if ($urandom_range(0, 1) == 0) draft[8] = CH_DOT;
        end else if (kind >= 92) begin
            // raw noise
            n = $urandom_range(1, 14);
            for (int k = 0; k < n; k++) draft.push_back(8'($urandom_range(1, 255)));
        end
        commit_draft();
    endtask

    initial begin
        int directed_count;
        foreach (seen_chars[k]) seen_chars[k] = 8'h00;

        // Directed names: empty, lone dot, double dot, lower case and extreme bytes,
        // full-width base and extension, the punctuation that is allowed
        push_text("");
        push_text(".");
        push_text("A..");
        draft.push_back("a");
        draft.push_back(8'h01);
        draft.push_back(8'hFF);
        commit_draft();
        push_text("ABCDEFGH.XYZ");
        push_text("_-09");
        directed_count = pending_chars.size();

        while (pending_chars.size() < directed_count + RANDOM_CHARS) make_random_name();
        stim_total = pending_chars.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() != 0 || i_valid) @(posedge i_clk);
        while (name_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d characters in %0d names, %0d of them legal short names,",
                 sent_count, names_checked, names_valid);
        $display("through three mixes of sender gaps and receiver stalls, %0d errors",
                 error_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
